/* sv/ftb_pkg.sv */
`timescale 1ns / 1ps

package ftb_pkg;

   localparam int unsigned StepW     = 17;
   localparam int unsigned DataW     = 32;
   localparam int unsigned ProdW     = StepW + DataW;
   localparam int unsigned DivSteps  = StepW;
   localparam int unsigned CntW      = $clog2(DivSteps);

   localparam logic [StepW-1:0] StepOne  = 17'd65536;
   localparam logic [StepW-1:0] StepMin  = 17'd1;
   localparam logic [StepW-1:0] TauReset = 17'd64881;

   // candidate slots: lower side first, then upper side
   localparam logic CandLower = 1'b0;
   localparam logic CandUpper = 1'b1;

   typedef struct packed {
      logic load;   // capture the incoming transaction
      logic mul;    // form tau * gap for the selected candidate
      logic sel;    // candidate slot used by mul
      logic init;   // seed the divider from the product
      logic iter;   // one restoring division step
      logic upd;    // fold the quotient into the running minimum
      logic emit;   // move the running minimum to the result register
   } dp_cmd_type;

   typedef struct packed {
      logic en_lower;
      logic en_upper;
      logic last;
      logic div_last;
      logic out_free;
   } dp_sts_type;

endpackage

/* sv/ftb_datapath.sv */
`timescale 1ns / 1ps

module ftb_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  ftb_pkg::dp_cmd_type                cmd,
   output ftb_pkg::dp_sts_type                sts,
   input  logic                               csr_write_enable,
   input  logic [ftb_pkg::StepW-1:0]          csr_write_data,
   input  logic                               req_mode,
   input  logic signed [ftb_pkg::DataW-1:0]   req_point,
   input  logic signed [ftb_pkg::DataW-1:0]   req_lo_limit,
   input  logic signed [ftb_pkg::DataW-1:0]   req_hi_limit,
   input  logic                               req_has_lower,
   input  logic                               req_has_upper,
   input  logic signed [ftb_pkg::DataW-1:0]   req_lower_multiplier,
   input  logic signed [ftb_pkg::DataW-1:0]   req_upper_multiplier,
   input  logic signed [ftb_pkg::DataW-1:0]   req_first_direction,
   input  logic signed [ftb_pkg::DataW-1:0]   req_second_direction,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ftb_pkg::StepW-1:0]          rsp_step_size
);
   import ftb_pkg::*;

   logic [StepW-1:0]  tau_ff, tau_in, tau_eff;
   logic [DataW-1:0]  gap0_ff, gap0_in, gap1_ff, gap1_in;
   logic [DataW-1:0]  mag0_ff, mag0_in, mag1_ff, mag1_in;
   logic              en0_ff, en0_in, en1_ff, en1_in, last_ff, last_in;
   logic [ProdW-1:0]  prod_ff, prod_in;
   logic [DataW-1:0]  mag_ff, mag_in, rem_ff, rem_in;
   logic [StepW-1:0]  low_ff, low_in, quo_ff, quo_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              ovf_ff, ovf_in;
   logic [StepW-1:0]  min_ff, min_in, qsat;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [StepW-1:0]  rsp_step_ff, rsp_step_in;

   logic signed [DataW:0] gap_lo, gap_up, neg_fd;
   logic signed [DataW-1:0] dir_up;
   logic [DataW:0]    trial, trial_sub;
   logic              trial_ge;
   logic [DataW-1:0]  gap_sel;

   assign tau_eff = (tau_ff > StepOne) ? StepOne : tau_ff;

   // gaps are formed one bit wider so the subtraction is exact
   always_comb begin
      gap_lo = req_mode ? {req_lower_multiplier[DataW-1], req_lower_multiplier}
                        : ({req_point[DataW-1], req_point}
                           - {req_lo_limit[DataW-1], req_lo_limit});
      gap_up = req_mode ? -{req_upper_multiplier[DataW-1], req_upper_multiplier}
                        : ({req_hi_limit[DataW-1], req_hi_limit}
                           - {req_point[DataW-1], req_point});
      dir_up = req_mode ? req_second_direction : req_first_direction;
      neg_fd = -{req_first_direction[DataW-1], req_first_direction};
      gap0_in = gap_lo[DataW-1:0];
      gap1_in = gap_up[DataW-1:0];
      mag0_in = neg_fd[DataW-1:0];
      mag1_in = dir_up;
      en0_in  = req_has_lower && req_first_direction < 0 && gap_lo > 0 && tau_ff != '0;
      en1_in  = req_has_upper && dir_up > 0 && gap_up > 0 && tau_ff != '0;
      last_in = req_last;
   end

   assign gap_sel = cmd.sel ? gap1_ff : gap0_ff;
   assign prod_in = {{DataW{1'b0}}, tau_eff} * {{StepW{1'b0}}, gap_sel};
   assign mag_in  = cmd.sel ? mag1_ff : mag0_ff;

   // restoring division step: shift in one numerator bit, subtract if it fits
   always_comb begin
      trial     = {rem_ff, low_ff[StepW-1]};
      trial_ge  = trial >= {1'b0, mag_ff};
      trial_sub = trial - {1'b0, mag_ff};
      rem_in    = rem_ff;
      low_in    = low_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      ovf_in    = ovf_ff;
      if (cmd.init) begin
         rem_in = prod_ff[ProdW-1:StepW];
         low_in = prod_ff[StepW-1:0];
         quo_in = '0;
         cnt_in = '0;
         ovf_in = prod_ff[ProdW-1:StepW] >= mag_ff;
      end else if (cmd.iter) begin
         rem_in = trial_ge ? trial_sub[DataW-1:0] : trial[DataW-1:0];
         low_in = {low_ff[StepW-2:0], 1'b0};
         quo_in = {quo_ff[StepW-2:0], trial_ge};
         cnt_in = cnt_ff + CntW'(1);
      end
   end

   always_comb begin
      if (ovf_ff || quo_ff > StepOne) begin
         qsat = StepOne;
      end else if (quo_ff == '0) begin
         qsat = StepMin;
      end else begin
         qsat = quo_ff;
      end
      min_in = min_ff;
      if (cmd.emit) begin
         min_in = StepOne;
      end else if (cmd.upd && qsat < min_ff) begin
         min_in = qsat;
      end
      rsp_step_in  = cmd.emit ? min_ff : rsp_step_ff;
      rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);
      tau_in       = csr_write_enable ? csr_write_data : tau_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tau_ff       <= TauReset;
         min_ff       <= StepOne;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         tau_ff       <= tau_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         gap0_ff <= gap0_in;
         gap1_ff <= gap1_in;
         mag0_ff <= mag0_in;
         mag1_ff <= mag1_in;
         en0_ff  <= en0_in;
         en1_ff  <= en1_in;
         last_ff <= last_in;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
         mag_ff  <= mag_in;
      end
      rem_ff      <= rem_in;
      low_ff      <= low_in;
      quo_ff      <= quo_in;
      ovf_ff      <= ovf_in;
      rsp_step_ff <= rsp_step_in;
   end

   always_comb begin
      sts.en_lower = en0_ff;
      sts.en_upper = en1_ff;
      sts.last     = last_ff;
      sts.div_last = cnt_ff == CntW'(DivSteps - 1);
      sts.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_step_size = rsp_step_ff;

   a_min_range: assert property (@(posedge clock) disable iff (reset)
      min_ff != '0 && min_ff <= StepOne)
      else $error("running minimum out of range");

   a_div_seed: assert property (@(posedge clock) disable iff (reset)
      cmd.init |=> (ovf_ff || rem_ff < mag_ff))
      else $error("divider seeded with remainder not below divisor");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (cmd.iter && !ovf_ff && rem_ff < mag_ff) |=> rem_ff < mag_ff)
      else $error("division step left remainder too large");

endmodule

/* sv/ftb_ctrl.sv */
`timescale 1ns / 1ps

module ftb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ftb_pkg::dp_sts_type  sts,
   output ftb_pkg::dp_cmd_type  cmd
);
   import ftb_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_NEXT = 7'b0000010,
      ST_MUL  = 7'b0000100,
      ST_INIT = 7'b0001000,
      ST_DIV  = 7'b0010000,
      ST_UPD  = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      sel_ff, sel_in;
   logic      cur_en;

   assign cur_en = (sel_ff == CandUpper) ? sts.en_upper : sts.en_lower;

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      cmd.sel  = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               sel_in   = CandLower;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (cur_en) begin
               state_in = ST_MUL;
            end else if (sel_ff == CandLower) begin
               sel_in = CandUpper;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_INIT;
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.iter = 1'b1;
            if (sts.div_last) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            cmd.upd = 1'b1;
            if (sel_ff == CandLower) begin
               sel_in   = CandUpper;
               state_in = ST_NEXT;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!sts.last) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = state_ff != ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= CandLower;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result emitted over a pending result");

   a_emit_last: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.last)
      else $error("result emitted for a non-final transaction");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_NEXT && sel_ff == CandLower)
      else $error("transaction not started on the lower side");

endmodule

/* sv/fraction_to_boundary_step.sv */
`timescale 1ns / 1ps

// Fraction-to-boundary step length. Each transaction carries one variable;
// up to two boundary candidates (lower side, upper side) are evaluated in turn
// on one 17x32 multiplier and one restoring divider that yields a 17-bit
// quotient one bit per cycle. Each active candidate takes a multiply, a
// divider seed, one division step per quotient bit and a minimum update.
// The step length is delivered through an output register on the transaction
// marked last, after which the running minimum returns to 1.0; the next
// transaction may be accepted while that result still waits, but a later
// last transaction holds in its final state for as long as rsp_stall keeps
// the earlier result in the register. tau is to be written only while the
// block is idle; the block itself does not enforce this.

module fraction_to_boundary_step (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [ftb_pkg::StepW-1:0]          csr_write_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_mode,
   input  logic signed [ftb_pkg::DataW-1:0]   req_point,
   input  logic signed [ftb_pkg::DataW-1:0]   req_lo_limit,
   input  logic signed [ftb_pkg::DataW-1:0]   req_hi_limit,
   input  logic                               req_has_lower,
   input  logic                               req_has_upper,
   input  logic signed [ftb_pkg::DataW-1:0]   req_lower_multiplier,
   input  logic signed [ftb_pkg::DataW-1:0]   req_upper_multiplier,
   input  logic signed [ftb_pkg::DataW-1:0]   req_first_direction,
   input  logic signed [ftb_pkg::DataW-1:0]   req_second_direction,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ftb_pkg::StepW-1:0]          rsp_step_size
);
   import ftb_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   ftb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ftb_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_mode             (req_mode),
      .req_point            (req_point),
      .req_lo_limit         (req_lo_limit),
      .req_hi_limit         (req_hi_limit),
      .req_has_lower        (req_has_lower),
      .req_has_upper        (req_has_upper),
      .req_lower_multiplier (req_lower_multiplier),
      .req_upper_multiplier (req_upper_multiplier),
      .req_first_direction  (req_first_direction),
      .req_second_direction (req_second_direction),
      .req_last             (req_last),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_step_size        (rsp_step_size)
   );

endmodule

/* sim/tb_fraction_to_boundary_step.sv */
`timescale 1ns / 1ps

module tb_fraction_to_boundary_step;
   import ftb_pkg::*;

   localparam int CycleLimit = 1000000;
   localparam int DrainWait  = 64;
   localparam int PhaseVars  = 225;
   localparam logic ModePrimal = 1'b0;
   localparam logic ModeDual   = 1'b1;

   typedef struct {
      logic                    mode;
      logic signed [DataW-1:0] point;
      logic signed [DataW-1:0] lo_limit;
      logic signed [DataW-1:0] hi_limit;
      logic                    has_lower;
      logic                    has_upper;
      logic signed [DataW-1:0] lower_multiplier;
      logic signed [DataW-1:0] upper_multiplier;
      logic signed [DataW-1:0] first_direction;
      logic signed [DataW-1:0] second_direction;
      logic                    last;
   } boundary_var_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_write_enable = 1'b0;
   logic [StepW-1:0]        csr_write_data = '0;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_mode = 1'b0;
   logic signed [DataW-1:0] req_point = '0;
   logic signed [DataW-1:0] req_lo_limit = '0;
   logic signed [DataW-1:0] req_hi_limit = '0;
   logic                    req_has_lower = 1'b0;
   logic                    req_has_upper = 1'b0;
   logic signed [DataW-1:0] req_lower_multiplier = '0;
   logic signed [DataW-1:0] req_upper_multiplier = '0;
   logic signed [DataW-1:0] req_first_direction = '0;
   logic signed [DataW-1:0] req_second_direction = '0;
   logic                    req_last = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [StepW-1:0]        rsp_step_size;

   boundary_var_type pending_vars[$];
   logic [StepW-1:0] step_expected[$];
   logic [StepW-1:0] tau_now = TauReset;
   logic [StepW-1:0] min_step = StepOne;
   bit               idle_on = 1'b1;
   int               queued_vars = 0;
   int               accepted_vars = 0;
   int               results_seen = 0;
   int               errors = 0;
   int               tau_writes = 0;
   int               cycle_count = 0;
   int               send_gap = 0;
   int               recv_hold = 0;
   boundary_var_type next_var;
   boundary_var_type seen_var;
   logic [StepW-1:0] want_step;

   fraction_to_boundary_step DUT (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_mode             (req_mode),
      .req_point            (req_point),
      .req_lo_limit         (req_lo_limit),
      .req_hi_limit         (req_hi_limit),
      .req_has_lower        (req_has_lower),
      .req_has_upper        (req_has_upper),
      .req_lower_multiplier (req_lower_multiplier),
      .req_upper_multiplier (req_upper_multiplier),
      .req_first_direction  (req_first_direction),
      .req_second_direction (req_second_direction),
      .req_last             (req_last),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_step_size        (rsp_step_size)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---- step size predictor ----

   function automatic void fold_candidate(longint gap, longint mag);
      longint unsigned t;
      longint unsigned q;
      t = (tau_now > StepOne) ? StepOne : tau_now;
      if (gap <= 0 || t == 0 || mag <= 0) return;
      q = (t * longint'(gap)) / longint'(mag);
      if (q > StepOne) q = StepOne;
      if (q == 0) q = 1;   // positive distance never rounds to zero
      if (q < min_step) min_step = q[StepW-1:0];
   endfunction

   function automatic void track_boundary(boundary_var_type v);
      longint d1;
      longint d2;
      d1 = longint'(v.first_direction);
      d2 = longint'(v.second_direction);
      if (v.mode == ModePrimal) begin
         if (v.has_lower && d1 < 0)
            fold_candidate(longint'(v.point) - longint'(v.lo_limit), -d1);
         if (v.has_upper && d1 > 0)
            fold_candidate(longint'(v.hi_limit) - longint'(v.point), d1);
      end else begin
         if (v.has_lower && d1 < 0)
            fold_candidate(longint'(v.lower_multiplier), -d1);
         if (v.has_upper && d2 > 0)
            fold_candidate(-longint'(v.upper_multiplier), d2);
      end
      if (v.last) begin
         step_expected.push_back(min_step);
         min_step = StepOne;
      end
   endfunction

   // ---- stimulus helpers ----

   function automatic boundary_var_type mk_var(logic mode, int point, int lb, int ub,
                                               logic hl, logic hu, int lm, int um,
                                               int d1, int d2, logic is_last);
      boundary_var_type v;
      v.mode = mode;
      v.point = point;
      v.lo_limit = lb;
      v.hi_limit = ub;
      v.has_lower = hl;
      v.has_upper = hu;
      v.lower_multiplier = lm;
      v.upper_multiplier = um;
      v.first_direction = d1;
      v.second_direction = d2;
      v.last = is_last;
      return v;
   endfunction

   task automatic queue_var(boundary_var_type v);
      pending_vars.push_back(v);
      queued_vars++;
   endtask

   function automatic int rand_word();
      int corner_words[5];
      corner_words = '{32'h7FFFFFFF, 32'h80000000, 0, 1, -1};
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
         2: return corner_words[$urandom_range(0, 4)];
         default: return int'($urandom_range(0, 1 << 25)) - (1 << 24);
      endcase
   endfunction

   // mostly gaps up to twice the direction, now and then at or below zero
   function automatic int near_gap(int mag);
      if ($urandom_range(0, 7) == 0) return -int'($urandom_range(0, mag));
      return int'($urandom_range(0, 2 * mag));
   endfunction

   function automatic boundary_var_type rand_var(logic is_last);
      boundary_var_type v;
      int mag1;
      int mag2;
      int p;
      v = mk_var($urandom_range(0, 1), rand_word(), rand_word(), rand_word(),
                 $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0,
                 rand_word(), rand_word(), rand_word(), rand_word(), is_last);
      if ($urandom_range(0, 4) != 0) begin
         mag1 = $urandom_range(1, 1 << 20);
         mag2 = $urandom_range(1, 1 << 20);
         p = int'($urandom_range(0, 1 << 25)) - (1 << 24);
         v.first_direction  = $urandom_range(0, 1) ? -mag1 : mag1;
         v.second_direction = $urandom_range(0, 1) ? mag2 : -mag2;
         v.point            = p;
         v.lo_limit         = p - near_gap(mag1);
         v.hi_limit         = p + near_gap(mag1);
         v.lower_multiplier = near_gap(mag1);
         v.upper_multiplier = -near_gap(mag2);
      end
      return v;
   endfunction

   task automatic queue_random_phase(int count);
      int target;
      int len;
      target = queued_vars + count;
      while (queued_vars < target) begin
         if ($urandom_range(0, 6) == 0) begin
            queue_var(rand_var($urandom_range(0, 1)));
         end else begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
               queue_var(rand_var(i == len - 1));
         end
      end
   endtask

   task automatic drain();
      do @(posedge clock);
      while (accepted_vars != queued_vars || step_expected.size() != 0);
      repeat (DrainWait) @(posedge clock);
   endtask

   task automatic write_tau(logic [StepW-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      tau_now = value;
      tau_writes++;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // ---- driver ----

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_vars.size() > 0) begin
            next_var = pending_vars.pop_front();
            req_mode             <= next_var.mode;
            req_point            <= next_var.point;
            req_lo_limit         <= next_var.lo_limit;
            req_hi_limit         <= next_var.hi_limit;
            req_has_lower        <= next_var.has_lower;
            req_has_upper        <= next_var.has_upper;
            req_lower_multiplier <= next_var.lower_multiplier;
            req_upper_multiplier <= next_var.upper_multiplier;
            req_first_direction  <= next_var.first_direction;
            req_second_direction <= next_var.second_direction;
            req_last             <= next_var.last;
            req_valid            <= 1'b1;
            if (idle_on && $urandom_range(0, 4) == 0)
               send_gap = $urandom_range(1, 4);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_hold = 0;
      end else if (recv_hold > 0) begin
         recv_hold--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         recv_hold = $urandom_range(1, 4) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---- monitor and scoreboard ----

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (step_expected.size() == 0) begin
               $display("%0t step_size: expected none, actual %0d", $time, rsp_step_size);
               errors++;
            end else begin
               want_step = step_expected.pop_front();
               results_seen++;
               if (rsp_step_size !== want_step) begin
                  $display("%0t step_size: expected %0d, actual %0d",
                           $time, want_step, rsp_step_size);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            seen_var = mk_var(req_mode, req_point, req_lo_limit, req_hi_limit,
                              req_has_lower, req_has_upper, req_lower_multiplier,
                              req_upper_multiplier, req_first_direction,
                              req_second_direction, req_last);
            track_boundary(seen_var);
            accepted_vars++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---- test sequence ----

   initial begin
      logic [StepW-1:0] tau_plan[8];
      tau_plan = '{StepOne, 17'd0, 17'h1FFFF, 17'd1, 17'd70000,
                   17'($urandom_range(2, 65535)), 17'd32768, TauReset};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed transactions at the reset value of tau
      queue_var(mk_var(ModePrimal, 32'h00010000, 0, 0, 1, 0, 0, 0, -32'h00020000, 0, 1));
      queue_var(mk_var(ModePrimal, 0, 0, 32'h00008000, 0, 1, 0, 0, 32'h00010000, 0, 1));
      // zero direction, both sides finite
      queue_var(mk_var(ModePrimal, 5, 0, 10, 1, 1, 0, 0, 0, 32'h00010000, 1));
      // gap at zero and below zero
      queue_var(mk_var(ModePrimal, 7, 7, 0, 1, 0, 0, 0, -1, 0, 0));
      queue_var(mk_var(ModePrimal, 3, 9, 1, 1, 1, 0, 0, 1, 0, 1));
      // far from the bound: saturates to one
      queue_var(mk_var(ModePrimal, 32'h00100000, 0, 0, 1, 0, 0, 0, -1, 0, 1));
      // tiny positive distance
      queue_var(mk_var(ModePrimal, 1, 0, 0, 1, 0, 0, 0, 32'h80000000, 0, 1));
      // widest gaps and directions
      queue_var(mk_var(ModePrimal, 32'h7FFFFFFF, 32'h80000000, 0, 1, 0, 0, 0,
                       32'h80000000, 0, 0));
      queue_var(mk_var(ModePrimal, 32'h80000000, 0, 32'h7FFFFFFF, 0, 1, 0, 0,
                       32'h7FFFFFFF, 0, 0));
      queue_var(mk_var(ModePrimal, 32'h00010000, 0, 0, 0, 1, 0, 0, -32'h00010000, 0, 1));
      queue_var(mk_var(ModeDual, 0, 0, 0, 1, 0, 32'h00010000, 0, -32'h00040000, 0, 0));
      queue_var(mk_var(ModeDual, 0, 0, 0, 0, 1, 0, -32'h00010000, 0, 32'h00080000, 1));
      queue_var(mk_var(ModeDual, 0, 0, 0, 0, 1, 0, 32'h80000000, 0, 32'h7FFFFFFF, 1));
      queue_var(mk_var(ModeDual, 0, 0, 0, 1, 1, 32'h00010000, -32'h00010000,
                       32'h00010000, -32'h00010000, 1));
      // dual mode ignores the primal fields, primal ignores the multipliers
      queue_var(mk_var(ModeDual, 32'h00010000, 0, 32'h00020000, 1, 1, -5, 5, -1, 1, 1));
      queue_var(mk_var(ModePrimal, 0, 32'h00010000, -1, 1, 1, 32'h00004000,
                       -32'h00004000, -1, 1, 1));
      queue_var(mk_var(ModeDual, -1, -1, -1, 1, 1, -1, -1, -1, -1, 1));
      queue_var(mk_var(ModePrimal, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      queue_var(mk_var(ModeDual, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 1,
                       32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 1));
      drain();

      foreach (tau_plan[i]) begin
         write_tau(tau_plan[i]);
         idle_on = !(i == 3 || i >= 6);
         queue_random_phase(PhaseVars);
         drain();
      end

      $display("Covered %0d variables, %0d step results checked, %0d tau writes.",
               accepted_vars, results_seen, tau_writes);
      $display("Mismatches: %0d", errors);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
